@@ src/cbdp_pkg.sv @@
package cbdp_pkg;

  localparam int unsigned DATA_W = 16;
  localparam int unsigned LANES = 8;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned OUT_W = 52;

  localparam int unsigned CODEBOOK_ENTRIES_DEF = 256;
  localparam int unsigned GROUPS_PER_BLOCK_DEF = 4;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam int unsigned DOT_W = PROD_W + $clog2(LANES);
  localparam int unsigned TERM_W = DOT_W + DATA_W;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_DOT   = 1'b1
  } cmd_e;

  typedef logic [LANES-1:0][DATA_W-1:0] row_t;

  typedef struct packed {
    logic              is_dot;
    logic              in_range;
    logic [IDX_W-1:0]  index;
    row_t              lanes;
    logic [DATA_W-1:0] scale;
  } item_t;

endpackage

@@ src/cbdp_if.sv @@
interface cbdp_in_if;
  logic                                valid;
  logic                                ready;
  logic                                cmd;
  logic [cbdp_pkg::IDX_W-1:0]          code_index;
  logic signed [cbdp_pkg::DATA_W-1:0]  lane0;
  logic signed [cbdp_pkg::DATA_W-1:0]  lane1;
  logic signed [cbdp_pkg::DATA_W-1:0]  lane2;
  logic signed [cbdp_pkg::DATA_W-1:0]  lane3;
  logic signed [cbdp_pkg::DATA_W-1:0]  lane4;
  logic signed [cbdp_pkg::DATA_W-1:0]  lane5;
  logic signed [cbdp_pkg::DATA_W-1:0]  lane6;
  logic signed [cbdp_pkg::DATA_W-1:0]  lane7;
  logic signed [cbdp_pkg::DATA_W-1:0]  scale;

  modport source (
    output valid, cmd, code_index, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7,
           scale,
    input  ready
  );

  modport sink (
    input  valid, cmd, code_index, lane0, lane1, lane2, lane3, lane4, lane5, lane6, lane7,
           scale,
    output ready
  );
endinterface

interface cbdp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [cbdp_pkg::OUT_W-1:0]  block_dot;

  modport source (
    output valid, block_dot,
    input  ready
  );

  modport sink (
    input  valid, block_dot,
    output ready
  );
endinterface

@@ src/cbdp_front.sv @@
module cbdp_front #(
  parameter int unsigned CODEBOOK_ENTRIES = cbdp_pkg::CODEBOOK_ENTRIES_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  cbdp_in_if.sink         in_ch_i,
  output logic            q_valid_o,
  input  logic            q_ready_i,
  output cbdp_pkg::item_t q_item_o
);

  cbdp_pkg::item_t                    queue_q [cbdp_pkg::QUEUE_DEPTH];
  cbdp_pkg::item_t                    item_d;
  logic [cbdp_pkg::QPTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [cbdp_pkg::QPTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [cbdp_pkg::QCNT_W-1:0]        count_q, count_d;
  logic                               push;
  logic                               pop;

  always_comb begin
    item_d.is_dot   = (cbdp_pkg::cmd_e'(in_ch_i.cmd) == cbdp_pkg::CMD_DOT);
    item_d.in_range = (32'(in_ch_i.code_index) < 32'(CODEBOOK_ENTRIES));
    item_d.index    = in_ch_i.code_index;
    item_d.lanes    = {in_ch_i.lane7, in_ch_i.lane6, in_ch_i.lane5, in_ch_i.lane4,
                       in_ch_i.lane3, in_ch_i.lane2, in_ch_i.lane1, in_ch_i.lane0};
    item_d.scale    = in_ch_i.scale;
  end

  assign in_ch_i.ready = (count_q != cbdp_pkg::QCNT_W'(cbdp_pkg::QUEUE_DEPTH));
  assign push          = in_ch_i.valid && in_ch_i.ready;
  assign q_valid_o     = (count_q != '0);
  assign pop           = q_valid_o && q_ready_i;
  assign q_item_o      = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= item_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cbdp_pkg::QCNT_W'(cbdp_pkg::QUEUE_DEPTH))
    else $error("Queue count exceeds its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("Queue count did not drop after a pop.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("Empty queue has mismatched pointers.");

endmodule

@@ src/cbdp_back.sv @@
module cbdp_back #(
  parameter int unsigned CODEBOOK_ENTRIES = cbdp_pkg::CODEBOOK_ENTRIES_DEF,
  parameter int unsigned GROUPS_PER_BLOCK = cbdp_pkg::GROUPS_PER_BLOCK_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  output logic            q_ready_o,
  input  cbdp_pkg::item_t q_item_i,
  cbdp_out_if.source      out_ch_o
);

  localparam int unsigned AW    = $clog2(CODEBOOK_ENTRIES);
  localparam int unsigned CNT_W = $clog2(GROUPS_PER_BLOCK + 1);

  cbdp_pkg::row_t mem_q [CODEBOOK_ENTRIES];

  logic [cbdp_pkg::IDX_W+AW-1:0]          idx_wide;
  logic [AW-1:0]                          addr;
  logic                                   en;
  logic                                   pop;

  logic                                   v1_q, rng1_q;
  cbdp_pkg::row_t                         rd1_q;
  cbdp_pkg::row_t                         act1_q;
  logic [cbdp_pkg::DATA_W-1:0]            scale1_q;

  logic                                   v2_q;
  logic signed [cbdp_pkg::PROD_W-1:0]     prod2_q [cbdp_pkg::LANES];
  logic [cbdp_pkg::DATA_W-1:0]            scale2_q;

  logic                                   v3_q;
  logic signed [cbdp_pkg::DOT_W-1:0]      dot3_q, dot3_d;
  logic [cbdp_pkg::DATA_W-1:0]            scale3_q;

  logic                                   v4_q;
  logic signed [cbdp_pkg::TERM_W-1:0]     term4_q, term4_d;

  logic signed [cbdp_pkg::OUT_W-1:0]      acc_q, acc_sum;
  logic [CNT_W-1:0]                       cnt_q;
  logic                                   last;
  logic                                   out_valid_q;
  logic signed [cbdp_pkg::OUT_W-1:0]      out_data_q;

  assign idx_wide  = (cbdp_pkg::IDX_W + AW)'(q_item_i.index);
  assign addr      = idx_wide[AW-1:0];
  assign en        = !out_valid_q || out_ch_o.ready;
  assign q_ready_o = en;
  assign pop       = q_valid_i && en;

  always_ff @(posedge clk_i) begin
    if (pop && !q_item_i.is_dot && q_item_i.in_range) begin
      mem_q[addr] <= q_item_i.lanes;
    end
    if (pop && q_item_i.is_dot) begin
      rd1_q <= mem_q[addr];
    end
  end

  always_comb begin
    dot3_d = '0;
    for (int i = 0; i < cbdp_pkg::LANES; i++) begin
      dot3_d = dot3_d + cbdp_pkg::DOT_W'(prod2_q[i]);
    end
  end

  assign term4_d = dot3_q * $signed(scale3_q);
  assign acc_sum = acc_q + cbdp_pkg::OUT_W'(term4_q);
  assign last    = (cnt_q == CNT_W'(GROUPS_PER_BLOCK - 1));

  always_ff @(posedge clk_i) begin
    if (en) begin
      rng1_q   <= q_item_i.in_range;
      act1_q   <= q_item_i.lanes;
      scale1_q <= q_item_i.scale;
      for (int i = 0; i < cbdp_pkg::LANES; i++) begin
        if (rng1_q) begin
          prod2_q[i] <= $signed(rd1_q[i]) * $signed(act1_q[i]);
        end else begin
          prod2_q[i] <= '0;
        end
      end
      scale2_q <= scale1_q;
      dot3_q   <= dot3_d;
      scale3_q <= scale2_q;
      term4_q  <= term4_d;
    end
    if (en && v4_q && last) begin
      out_data_q <= acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (en) begin
        v1_q <= pop && q_item_i.is_dot;
        v2_q <= v1_q;
        v3_q <= v2_q;
        v4_q <= v3_q;
        if (v4_q) begin
          if (last) begin
            acc_q <= '0;
            cnt_q <= '0;
          end else begin
            acc_q <= acc_sum;
            cnt_q <= cnt_q + 1'b1;
          end
        end
      end
      if (en && v4_q && last) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_ch_o.valid     = out_valid_q;
  assign out_ch_o.block_dot = out_data_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(GROUPS_PER_BLOCK))
    else $error("Group counter passed the block length.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en && v4_q && last) |=> (acc_q == '0 && out_valid_q))
    else $error("Block end did not emit and clear the accumulator.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(v4_q) && $stable(acc_q) && $stable(cnt_q)))
    else $error("Pipeline moved while the output was stalled.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ch_o.ready) |-> !q_ready_o)
    else $error("Queue popped while a result was stalled.");

endmodule

@@ src/codebook_block_dot_product.sv @@
// Channel   Direction  Content                                          Accepted when
// in_ch_i   input      cmd, code_index, lane0..lane7, scale             valid && ready
// out_ch_o  output     block_dot (one per GROUPS_PER_BLOCK dot items)    valid && ready
//
// The back end takes one queued transaction per cycle, so the sustained rate is one item per
// cycle while results are taken; a dot item waits in the four-entry queue, passes the read,
// product, sum and term registers, and the block result is loaded as its last group is added.
// A result that is not taken stalls the back end; the queue keeps accepting until full.
// Reset clears the queue, the pipeline valids, the accumulator and the group count.
// The codebook memory has no reset and must be written before it is read.
module codebook_block_dot_product #(
  parameter int unsigned CODEBOOK_ENTRIES = cbdp_pkg::CODEBOOK_ENTRIES_DEF,
  parameter int unsigned GROUPS_PER_BLOCK = cbdp_pkg::GROUPS_PER_BLOCK_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cbdp_in_if.sink    in_ch_i,
  cbdp_out_if.source out_ch_o
);

  logic            q_valid;
  logic            q_ready;
  cbdp_pkg::item_t q_item;

  cbdp_front #(
    .CODEBOOK_ENTRIES(CODEBOOK_ENTRIES)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch_i),
    .q_valid_o(q_valid),
    .q_ready_i(q_ready),
    .q_item_o (q_item)
  );

  cbdp_back #(
    .CODEBOOK_ENTRIES(CODEBOOK_ENTRIES),
    .GROUPS_PER_BLOCK(GROUPS_PER_BLOCK)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_valid_i(q_valid),
    .q_ready_o(q_ready),
    .q_item_i (q_item),
    .out_ch_o (out_ch_o)
  );

endmodule

@@ verif/cbdp_block_checker.sv @@
module cbdp_block_checker
  import cbdp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  cbdp_in_if   in_mon_i,
  cbdp_out_if  out_mon_i,
  output int   errors_o,
  output int   pending_o,
  output int   blocks_o,
  output int   dots_o,
  output int   writes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  row_t             cb_rows [CODEBOOK_ENTRIES_DEF];
  logic [OUT_W-1:0] acc_sum = '0;
  int unsigned      groups_seen = 0;
  logic [OUT_W-1:0] block_sums_q [$];
  int               err_count = 0;
  int               block_count = 0;
  int               dot_count = 0;
  int               write_count = 0;

  // Exact scaled dot product of one group, reduced to the result width.
  function automatic logic [OUT_W-1:0] scaled_group(row_t weights, row_t acts,
                                                    logic [DATA_W-1:0] scale);
    longint sum;
    sum = 0;
    for (int l = 0; l < LANES; l++) begin
      sum += longint'($signed(weights[l])) * longint'($signed(acts[l]));
    end
    return OUT_W'(sum * longint'($signed(scale)));
  endfunction

  always @(posedge clk_i) begin : monitor
    row_t             acts;
    logic [OUT_W-1:0] expected;
    if (rst_ni) begin
      // A result taken at this edge can only come from earlier transactions.
      if (out_mon_i.valid && out_mon_i.ready) begin
        block_count++;
        if (block_sums_q.size() == 0) begin
          $display("%t: unexpected block_dot, expected none, actual %h",
                   $time, out_mon_i.block_dot);
          err_count++;
        end else begin
          expected = block_sums_q.pop_front();
          if (out_mon_i.block_dot !== expected) begin
            $display("%t: block_dot mismatch, expected %h, actual %h",
                     $time, expected, out_mon_i.block_dot);
            err_count++;
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        acts = {in_mon_i.lane7, in_mon_i.lane6, in_mon_i.lane5, in_mon_i.lane4,
                in_mon_i.lane3, in_mon_i.lane2, in_mon_i.lane1, in_mon_i.lane0};
        if (cmd_e'(in_mon_i.cmd) == CMD_WRITE) begin
          write_count++;
          if (in_mon_i.code_index < CODEBOOK_ENTRIES_DEF) begin
            cb_rows[in_mon_i.code_index] = acts;
          end
        end else begin
          dot_count++;
          acc_sum = acc_sum + scaled_group(cb_rows[in_mon_i.code_index], acts,
                                           in_mon_i.scale);
          groups_seen++;
          if (groups_seen == GROUPS_PER_BLOCK_DEF) begin
            block_sums_q.push_back(acc_sum);
            acc_sum     = '0;
            groups_seen = 0;
          end
        end
      end
      errors_o  <= err_count;
      pending_o <= block_sums_q.size();
      blocks_o  <= block_count;
      dots_o    <= dot_count;
      writes_o  <= write_count;
    end
  end

endmodule

@@ verif/codebook_block_dot_product_test.sv @@
module codebook_block_dot_product_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbdp_pkg::*;

  localparam int RANDOM_ITEMS = 500;
  localparam int STEADY_TAIL  = 80;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 12;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady = 1'b0;
  int   idle_cycles = 0;
  int   failures;
  int   pending;
  int   blocks;
  int   dots;
  int   writes;

  bit               row_written [CODEBOOK_ENTRIES_DEF];
  logic [IDX_W-1:0] written_rows [$];

  cbdp_in_if  in_ch ();
  cbdp_out_if out_ch ();

  codebook_block_dot_product u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  cbdp_block_checker u_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_mon_i (in_ch),
    .out_mon_i(out_ch),
    .errors_o (failures),
    .pending_o(pending),
    .blocks_o (blocks),
    .dots_o   (dots),
    .writes_o (writes)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Lane values lean toward the corners of the signed range.
  function automatic logic [DATA_W-1:0] rand_lane();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return DATA_W'($urandom);
    endcase
  endfunction

  function automatic row_t rand_row();
    row_t r;
    for (int l = 0; l < LANES; l++) begin
      r[l] = rand_lane();
    end
    return r;
  endfunction

  task automatic send_item(input cmd_e cmd, input logic [IDX_W-1:0] idx, input row_t lanes,
                           input logic [DATA_W-1:0] scale);
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.code_index <= idx;
    in_ch.lane0      <= lanes[0];
    in_ch.lane1      <= lanes[1];
    in_ch.lane2      <= lanes[2];
    in_ch.lane3      <= lanes[3];
    in_ch.lane4      <= lanes[4];
    in_ch.lane5      <= lanes[5];
    in_ch.lane6      <= lanes[6];
    in_ch.lane7      <= lanes[7];
    in_ch.scale      <= scale;
    do @(posedge clk_i); while (!in_ch.ready);
    if (cmd == CMD_WRITE && !row_written[idx]) begin
      row_written[idx] = 1'b1;
      written_rows.push_back(idx);
    end
    if (!steady && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!steady && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Watchdog expired after %0d cycles without a transaction.", IDLE_LIMIT);
      $display("codebook_block_dot_product_test NOT OK");
      $finish;
    end
  end

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_WRITE;
    in_ch.code_index <= '0;
    in_ch.lane0      <= '0;
    in_ch.lane1      <= '0;
    in_ch.lane2      <= '0;
    in_ch.lane3      <= '0;
    in_ch.lane4      <= '0;
    in_ch.lane5      <= '0;
    in_ch.lane6      <= '0;
    in_ch.lane7      <= '0;
    in_ch.scale      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Rows at the corners of the value range, lowest and highest index.
    send_item(CMD_WRITE, 8'h00, {LANES{16'h8000}}, 16'h0000);
    send_item(CMD_WRITE, 8'hff, {LANES{16'h7fff}}, 16'hffff);
    send_item(CMD_WRITE, 8'h55, {4{16'h8000, 16'h7fff}}, 16'h8000);
    send_item(CMD_WRITE, 8'haa, rand_row(), 16'h7fff);

    // Largest magnitude the block can reach.
    repeat (4) send_item(CMD_DOT, 8'h00, {LANES{16'h8000}}, 16'h8000);
    repeat (4) send_item(CMD_DOT, 8'hff, {LANES{16'h8000}}, 16'h7fff);

    // A block split by a write that replaces a row it already used.
    send_item(CMD_DOT, 8'h55, {4{16'h7fff, 16'h8000}}, 16'h7fff);
    send_item(CMD_WRITE, 8'h55, {LANES{16'h0001}}, 16'h1234);
    send_item(CMD_DOT, 8'h55, {LANES{16'hffff}}, 16'hffff);
    send_item(CMD_DOT, 8'haa, {LANES{16'h0000}}, 16'h7fff);
    send_item(CMD_DOT, 8'h00, rand_row(), 16'h0000);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= RANDOM_ITEMS - STEADY_TAIL);
      if ($urandom_range(0, 3) == 0) begin
        send_item(CMD_WRITE, IDX_W'($urandom_range(0, CODEBOOK_ENTRIES_DEF - 1)), rand_row(),
                  DATA_W'($urandom));
      end else begin
        send_item(CMD_DOT, written_rows[$urandom_range(0, written_rows.size() - 1)],
                  rand_row(), rand_lane());
      end
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d codebook writes over %0d distinct rows and %0d dot groups.",
             writes, written_rows.size(), dots);
    $display("%0d block results were compared, %0d mismatches found.", blocks, failures);
    if (failures == 0 && pending == 0) begin
      $display("codebook_block_dot_product_test OK");
    end else begin
      $display("codebook_block_dot_product_test NOT OK");
    end
    $finish;
  end

endmodule
